FILE: rtl/core/gem_pkg.sv
// ----------------------------------------------------------------------------
// gem_pkg
// Shared types and constants of the greedy bipartite edge matcher.
// ----------------------------------------------------------------------------
package gem_pkg;

  // Field widths fixed by the block's word formats.
  localparam int unsigned NODE_NUM_W = 16;
  localparam int unsigned CFG_W      = 11;
  localparam int unsigned CNT_W      = 11;
  localparam int unsigned EDGE_NUM_W = 17;
  localparam int unsigned CFG_IDX_W  = 2;

  // Width of the run tag kept with every node-store entry.
  localparam int unsigned EPOCH_W    = 8;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_NODES_A       = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_NODES_B       = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SECOND_ENABLE = 2'd2;

  typedef enum logic [2:0] {
    VERDICT_IGNORED = 3'd0,
    VERDICT_MATCHED = 3'd1,
    VERDICT_SECOND  = 3'd2,
    VERDICT_INVALID = 3'd3,
    VERDICT_SKIPPED = 3'd4
  } verdict_e;

  // Lookup request issued when an edge word is accepted.
  typedef struct packed {
    logic                  ren;
    logic [NODE_NUM_W-1:0] a_idx;
    logic [NODE_NUM_W-1:0] b_idx;
  } gem_rd_t;

  // Node marks as seen by the edge in the decision stage.
  typedef struct packed {
    logic a_taken;
    logic a_second;
    logic b_taken;
  } gem_lookup_t;

  // Update issued by the decision stage.
  typedef struct packed {
    logic                  a_we;
    logic                  b_we;
    logic [NODE_NUM_W-1:0] a_idx;
    logic [NODE_NUM_W-1:0] b_idx;
    logic                  a_second;
    logic                  run_end;
  } gem_wr_t;

  typedef struct packed {
    logic busy;        // clearing pass in progress
    logic epoch_last;  // the next list end wraps the run tag
  } gem_store_st_t;

endpackage

FILE: rtl/core/gem_edge_if.sv
// ----------------------------------------------------------------------------
// gem_edge_if
// Channel carrying one edge word: A node, B node and the last-edge flag.
// ----------------------------------------------------------------------------
interface gem_edge_if import gem_pkg::*; ();

  logic                  valid;
  logic                  ready;
  logic [NODE_NUM_W-1:0] a_node;
  logic [NODE_NUM_W-1:0] b_node;
  logic                  last_edge;

  modport source (output valid, a_node, b_node, last_edge, input ready);
  modport sink   (input valid, a_node, b_node, last_edge, output ready);

endinterface

FILE: rtl/core/gem_result_if.sv
// ----------------------------------------------------------------------------
// gem_result_if
// Channel carrying one result word per edge.
// ----------------------------------------------------------------------------
interface gem_result_if import gem_pkg::*; ();

  logic                  valid;
  logic                  ready;
  verdict_e              verdict;
  logic [NODE_NUM_W-1:0] node_a;
  logic [NODE_NUM_W-1:0] node_b;
  logic [EDGE_NUM_W-1:0] edge_number;
  logic [CNT_W-1:0]      match_count;
  logic                  list_end;

  modport source (output valid, verdict, node_a, node_b, edge_number, match_count,
                  list_end, input ready);
  modport sink   (input valid, verdict, node_a, node_b, edge_number, match_count,
                  list_end, output ready);

endinterface

FILE: rtl/core/gem_node_store.sv
// ----------------------------------------------------------------------------
// gem_node_store
// Per-node marks of sets A and B in two memories with registered reads, each entry
// tagged with the run it was written in, with write-to-read forwarding and a
// clearing pass after reset and whenever the run tag wraps.
// ----------------------------------------------------------------------------
module gem_node_store import gem_pkg::*; #(
  parameter int unsigned MAX_NODES = 1024
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  gem_rd_t       rd_i,
  input  gem_wr_t       wr_i,
  output gem_lookup_t   lookup_o,
  output gem_store_st_t status_o
);

  localparam int unsigned AW = $clog2(MAX_NODES);

  typedef logic [EPOCH_W+1:0] a_entry_t;  // {tag, taken, second}
  typedef logic [EPOCH_W:0]   b_entry_t;  // {tag, taken}

  a_entry_t a_mem [MAX_NODES];
  b_entry_t b_mem [MAX_NODES];

  a_entry_t a_rdata_q, a_fwd_q, a_wdata, a_ent;
  b_entry_t b_rdata_q, b_fwd_q, b_wdata, b_ent;
  logic     a_hit_q, a_hit_d, b_hit_q, b_hit_d;
  logic     a_we, b_we;
  logic [AW-1:0] a_waddr, b_waddr, a_raddr, b_raddr;

  logic [EPOCH_W-1:0] epoch_q, epoch_d;
  logic               clearing_q, clearing_d;
  logic [AW-1:0]      clr_ptr_q, clr_ptr_d;

  assign a_raddr = rd_i.a_idx[AW-1:0];
  assign b_raddr = rd_i.b_idx[AW-1:0];

  always_comb begin
    if (clearing_q) begin
      a_we    = 1'b1;
      b_we    = 1'b1;
      a_waddr = clr_ptr_q;
      b_waddr = clr_ptr_q;
      a_wdata = '0;
      b_wdata = '0;
    end else begin
      a_we    = wr_i.a_we;
      b_we    = wr_i.b_we;
      a_waddr = wr_i.a_idx[AW-1:0];
      b_waddr = wr_i.b_idx[AW-1:0];
      a_wdata = {epoch_q, 1'b1, wr_i.a_second};
      b_wdata = {epoch_q, 1'b1};
    end
    // A read sees the memory before a write on the same edge, so that write
    // is captured alongside the read.
    a_hit_d = a_we && (a_waddr == a_raddr);
    b_hit_d = b_we && (b_waddr == b_raddr);
  end

  always_ff @(posedge clk_i) begin
    if (a_we) begin
      a_mem[a_waddr] <= a_wdata;
    end
    if (b_we) begin
      b_mem[b_waddr] <= b_wdata;
    end
    if (rd_i.ren) begin
      a_rdata_q <= a_mem[a_raddr];
      b_rdata_q <= b_mem[b_raddr];
      a_fwd_q   <= a_wdata;
      b_fwd_q   <= b_wdata;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_hit_q <= 1'b0;
      b_hit_q <= 1'b0;
    end else if (rd_i.ren) begin
      a_hit_q <= a_hit_d;
      b_hit_q <= b_hit_d;
    end
  end

  // An entry written in an earlier run reads as clear.
  always_comb begin
    a_ent = a_hit_q ? a_fwd_q : a_rdata_q;
    b_ent = b_hit_q ? b_fwd_q : b_rdata_q;
    lookup_o.a_taken  = (a_ent[EPOCH_W+1:2] == epoch_q) && a_ent[1];
    lookup_o.a_second = (a_ent[EPOCH_W+1:2] == epoch_q) && a_ent[0];
    lookup_o.b_taken  = (b_ent[EPOCH_W:1] == epoch_q) && b_ent[0];
  end

  always_comb begin
    epoch_d    = epoch_q;
    clearing_d = clearing_q;
    clr_ptr_d  = clr_ptr_q;
    if (clearing_q) begin
      clr_ptr_d = clr_ptr_q + AW'(1);
      if (clr_ptr_q == AW'(MAX_NODES - 1)) begin
        clearing_d = 1'b0;
      end
    end else if (wr_i.run_end) begin
      epoch_d = epoch_q + EPOCH_W'(1);
      if (epoch_q == '1) begin
        clearing_d = 1'b1;
        clr_ptr_d  = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      epoch_q    <= '0;
      clearing_q <= 1'b1;
      clr_ptr_q  <= '0;
    end else begin
      epoch_q    <= epoch_d;
      clearing_q <= clearing_d;
      clr_ptr_q  <= clr_ptr_d;
    end
  end

  assign status_o.busy       = clearing_q;
  assign status_o.epoch_last = (epoch_q == '1);

endmodule

FILE: rtl/core/greedy_bipartite_edge_matcher.sv
// ----------------------------------------------------------------------------
// greedy_bipartite_edge_matcher
// Greedy matching of a best-first edge list over two node sets, one result
// word per edge word.
// ----------------------------------------------------------------------------
// The block takes one edge word per cycle while the output side keeps up and
// the node store is not clearing, and returns one result word per edge: the
// node-store read comes first, then the decision, which lands in the output
// register. The rate of one edge per cycle is set by the single read and
// write port of each node memory; the write of one edge is forwarded to the
// read of the next. After reset the node store runs a clearing pass over all
// MAX_NODES entries during which no edge word is accepted; configuration
// writes are taken as ever. The end of a list clears the marks at once by
// moving to a new run tag, and at every 256th list end the tag wraps, which
// costs a further clearing pass. A stalled output holds the pipeline and
// ready drops with it.
// ----------------------------------------------------------------------------
module greedy_bipartite_edge_matcher import gem_pkg::*; #(
  parameter int unsigned MAX_NODES = 1024,
  parameter int unsigned MAX_EDGES = 65536
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_data_i,
  gem_edge_if.sink             edge_i,
  gem_result_if.source         result_o
);

  localparam int unsigned ECW = $clog2(MAX_EDGES + 1);

  // Configuration registers.
  logic [CFG_W-1:0] nodes_a_q, nodes_b_q;
  logic             second_en_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nodes_a_q   <= CFG_W'(1024);
      nodes_b_q   <= CFG_W'(1024);
      second_en_q <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_NODES_A:       nodes_a_q   <= cfg_data_i;
        REG_NODES_B:       nodes_b_q   <= cfg_data_i;
        REG_SECOND_ENABLE: second_en_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Handshake and pipeline control. The whole pipeline moves when the
  // output register is empty or its word is being taken.
  logic          advance, edge_accept, fire;
  logic          s1_valid_q, out_valid_q;
  gem_store_st_t store_st;
  gem_rd_t       rd_req;
  gem_wr_t       wr_req;
  gem_lookup_t   lookup;

  // Stage one payload: the edge whose marks are being read.
  logic [NODE_NUM_W-1:0] a_q, b_q;
  logic                  last_q;

  // Run state.
  logic [CNT_W-1:0] matches_q, matches_d;
  logic [ECW-1:0]   cnt_q, cnt_d, cnt_next;
  logic             stopped_q, stopped_d;

  // Output register payload.
  verdict_e              out_verdict_q;
  logic [NODE_NUM_W-1:0] out_a_q, out_b_q;
  logic [EDGE_NUM_W-1:0] out_edge_q;
  logic [CNT_W-1:0]      out_count_q;
  logic                  out_last_q;

  assign advance = !out_valid_q || result_o.ready;

  // A list end that wraps the run tag starts a clearing pass, so nothing may
  // be read behind it.
  assign edge_i.ready = advance && !store_st.busy &&
                        !(s1_valid_q && last_q && store_st.epoch_last);
  assign edge_accept  = edge_i.valid && edge_i.ready;
  assign fire         = s1_valid_q && advance;

  assign rd_req.ren   = edge_accept;
  assign rd_req.a_idx = edge_i.a_node - NODE_NUM_W'(1);
  assign rd_req.b_idx = edge_i.b_node - NODE_NUM_W'(1);

  gem_node_store #(
    .MAX_NODES (MAX_NODES)
  ) u_store (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .rd_i     (rd_req),
    .wr_i     (wr_req),
    .lookup_o (lookup),
    .status_o (store_st)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (advance) begin
      s1_valid_q <= edge_accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (edge_accept) begin
      a_q    <= edge_i.a_node;
      b_q    <= edge_i.b_node;
      last_q <= edge_i.last_edge;
    end
  end

  // Decision stage.
  logic [CFG_W-1:0] na, nb, limit;
  verdict_e         verdict;

  always_comb begin
    // Node counts above the store depth act as the store depth.
    na    = (32'(nodes_a_q) > MAX_NODES) ? CFG_W'(MAX_NODES) : nodes_a_q;
    nb    = (32'(nodes_b_q) > MAX_NODES) ? CFG_W'(MAX_NODES) : nodes_b_q;
    limit = (na < nb) ? na : nb;

    cnt_next  = (cnt_q < ECW'(MAX_EDGES)) ? cnt_q + ECW'(1) : cnt_q;
    matches_d = matches_q;
    stopped_d = stopped_q;
    verdict   = VERDICT_IGNORED;

    wr_req          = '0;
    wr_req.a_idx    = a_q - NODE_NUM_W'(1);
    wr_req.b_idx    = b_q - NODE_NUM_W'(1);
    wr_req.a_second = lookup.a_second;

    // Order of precedence: stopped run, full matching, range, second, match.
    if (stopped_q) begin
      verdict = VERDICT_SKIPPED;
    end else if ((matches_q != '0) && (matches_q >= limit)) begin
      verdict = VERDICT_IGNORED;
    end else if ((a_q == '0) || (a_q > NODE_NUM_W'(na)) ||
                 (b_q == '0) || (b_q > NODE_NUM_W'(nb))) begin
      verdict   = VERDICT_INVALID;
      stopped_d = 1'b1;
    end else if (lookup.a_taken) begin
      if (second_en_q && !lookup.a_second) begin
        verdict         = VERDICT_SECOND;
        wr_req.a_we     = fire;
        wr_req.a_second = 1'b1;
      end
    end else if (!lookup.b_taken) begin
      verdict     = VERDICT_MATCHED;
      wr_req.a_we = fire;
      wr_req.b_we = fire;
      matches_d   = matches_q + CNT_W'(1);
    end

    wr_req.run_end = fire && last_q;

    cnt_d = cnt_next;
    if (last_q) begin
      cnt_d     = '0;
      matches_d = '0;
      stopped_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      matches_q <= '0;
      cnt_q     <= '0;
      stopped_q <= 1'b0;
    end else if (fire) begin
      matches_q <= matches_d;
      cnt_q     <= cnt_d;
      stopped_q <= stopped_d;
    end
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_verdict_q <= verdict;
      out_a_q       <= a_q;
      out_b_q       <= b_q;
      out_edge_q    <= EDGE_NUM_W'(cnt_next);
      out_count_q   <= (verdict == VERDICT_MATCHED) ? matches_q + CNT_W'(1) : matches_q;
      out_last_q    <= last_q;
    end
  end

  assign result_o.valid       = out_valid_q;
  assign result_o.verdict     = out_verdict_q;
  assign result_o.node_a      = out_a_q;
  assign result_o.node_b      = out_b_q;
  assign result_o.edge_number = out_edge_q;
  assign result_o.match_count = out_count_q;
  assign result_o.list_end    = out_last_q;

  // A matched edge always leaves at least one match on the count.
  a_matched_counts : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (result_o.valid && (result_o.verdict == VERDICT_MATCHED)) |-> (result_o.match_count != '0)
  ) else $error("matched word with a zero match count");

  // The end of a list leaves the run state clear for the next one.
  a_list_end_clears : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (fire && last_q) |=> ((matches_q == '0) && (cnt_q == '0) && !stopped_q)
  ) else $error("run state not cleared after the last edge");

  // No edge may enter while the node store is being swept.
  a_no_accept_clearing : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    store_st.busy |-> !edge_accept
  ) else $error("edge accepted during the clearing pass");

  // A word that stays unaccepted keeps the decision stage frozen.
  a_stall_holds_state : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !result_o.ready) |=> ($stable(matches_q) && $stable(cnt_q))
  ) else $error("run state moved while the output stalled");

endmodule
